[hw/rtl/ifmt_pkg.sv]
// ----------------------------------------------------------------------------
// ifmt_pkg: shared types and constants of the integer field formatter
// Conversion and length codes, character codes, controller states, emit
// segments and the command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    // Saturation defaults for width and precision
    localparam int MAX_WIDTH_DEF     = 48;
    localparam int MAX_PRECISION_DEF = 48;

    // Conversion codes
    localparam logic [2:0] CONV_SDEC = 3'd0;
    localparam logic [2:0] CONV_UDEC = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_HEXL = 3'd3;
    localparam logic [2:0] CONV_HEXU = 3'd4;
    localparam logic [2:0] CONV_PTR  = 3'd5;
    localparam logic [2:0] CONV_CHAR = 3'd6;
    localparam logic [2:0] CONV_ALT  = 3'd7;

    // Length codes
    localparam logic [2:0] LEN_LL    = 3'd2;
    localparam logic [2:0] LEN_SHORT = 3'd3;
    localparam logic [2:0] LEN_CHAR  = 3'd4;

    // Sign modes
    localparam logic [1:0] SMODE_SPACE = 2'd1;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LC  = 8'h78;
    localparam logic [7:0] CH_X_UC  = 8'h58;

    localparam logic [127:0] DIGITS_LC = "0123456789abcdef";
    localparam logic [127:0] DIGITS_UC = "0123456789ABCDEF";

    // Digit store: 22 octal digits of 64 bits plus one octal leading zero
    localparam int DIG_N   = 23;
    localparam int DIG_W   = 5;
    localparam int BCD_N   = 20;
    localparam int CNT_W   = 7;
    localparam int STEP_W  = 5;
    localparam int SEG_N   = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_PLAN,
        ST_FIRST,
        ST_EMIT
    } state_t;

    // Emit segments, in output order
    typedef enum logic [2:0] {
        SEG_LPAD,
        SEG_SIGN,
        SEG_PRE0,
        SEG_PREX,
        SEG_ZPAD,
        SEG_PZERO,
        SEG_DIGIT,
        SEG_RPAD
    } seg_t;

    typedef struct packed {
        logic accept;
        logic conv_step;
        logic size_calc;
        logic plan;
        logic emit;
        logic load;
        seg_t seg;
        seg_t load_seg;
    } cmd_t;

    typedef struct packed {
        logic             conv_done;
        logic             cnt_last;
        logic             out_last;
        logic             empty;
        logic [SEG_N-1:0] seg_mask;
    } sts_t;

    // Map a digit value to its character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (upper)
            c = DIGITS_UC[8*(15-int'(d)) +: 8];
        else
            c = DIGITS_LC[8*(15-int'(d)) +: 8];
        return c;
    endfunction

    // First segment at or after from whose mask bit is set
    function automatic seg_t find_seg(input logic [SEG_N-1:0] mask, input logic [3:0] from);
        seg_t res;
        res = SEG_RPAD;
        for (int i = SEG_N - 1; i >= 0; i--)
        begin
            if (4'(i) >= from && mask[i])
                res = seg_t'(3'(i));
        end
        return res;
    endfunction

endpackage

[hw/rtl/ifmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ifmt_ctrl: formatter sequencer
// Steps a request through conversion, sizing and planning, then walks the
// emit segments in order, skipping empty ones, one character per cycle.
// ----------------------------------------------------------------------------
module ifmt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output ifmt_pkg::cmd_t cmd,
    input  ifmt_pkg::sts_t sts
);
    import ifmt_pkg::*;

    state_t state_reg, state_next;
    seg_t   seg_reg, seg_next;
    seg_t   found;

    // Hold state and current segment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= SEG_LPAD;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        cmd          = '0;
        cmd.seg      = seg_reg;
        cmd.load_seg = seg_reg;
        found        = SEG_LPAD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_done)
                    state_next = ST_SIZE;
                else
                    cmd.conv_step = 1'b1;
            end
            ST_SIZE:
            begin
                cmd.size_calc = 1'b1;
                state_next    = ST_PLAN;
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                if (sts.empty)
                    state_next = ST_IDLE;
                else
                begin
                    found        = find_seg(sts.seg_mask, 4'd0);
                    cmd.load     = 1'b1;
                    cmd.load_seg = found;
                    seg_next     = found;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.cnt_last)
                begin
                    if (sts.out_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        // advance to the next non-empty segment
                        found        = find_seg(sts.seg_mask, {1'b0, seg_reg} + 4'd1);
                        cmd.load     = 1'b1;
                        cmd.load_seg = found;
                        seg_next     = found;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/ifmt_dpath.sv]
// ----------------------------------------------------------------------------
// ifmt_dpath: formatter datapath
// Cuts and signs the value, builds the digit store (BCD by shift-add-3 four
// bits a cycle, or direct octal/hex slicing), sizes the field, plans the
// padding runs and drives the registered character word.
// ----------------------------------------------------------------------------
module ifmt_dpath #(
    parameter int MAX_WIDTH     = ifmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PRECISION = ifmt_pkg::MAX_PRECISION_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ifmt_pkg::cmd_t cmd,
    output ifmt_pkg::sts_t sts,
    input  logic [2:0]     conversion,
    input  logic [2:0]     length,
    input  logic [63:0]    value,
    input  logic           left_adjust,
    input  logic           zero_pad,
    input  logic           alternate,
    input  logic [1:0]     sign_mode,
    input  logic [5:0]     width,
    input  logic           has_precision,
    input  logic [5:0]     precision,
    output logic           strobe,
    output logic [7:0]     character,
    output logic           last
);
    import ifmt_pkg::*;

    // Request registers
    logic [2:0]        conv_reg;
    logic              ladj_reg, zpad_reg, alt_reg, hasp_reg;
    logic [5:0]        wid_reg, prec_reg;
    logic              has_sign_reg, hexpre_reg, upper_reg, mag_nz_reg;
    logic [7:0]        sign_reg, chr_reg;
    logic [63:0]       bin_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [3:0]        dig_reg [DIG_N];

    // Plan registers
    logic [DIG_W-1:0]  size_reg;
    logic [CNT_W-1:0]  lpad_reg, zrun_reg, pz_reg, rpad_reg;
    logic [CNT_W-1:0]  left_reg, cnt_reg;

    // Output word
    logic       strobe_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // Accept-side decode
    logic [2:0]        conv_n;
    logic [63:0]       mask, cut, mag, aligned;
    logic              sbit, neg;
    logic [7:0]        sign_ch;
    logic              sign_on;
    logic [STEP_W-1:0] steps_n;
    logic [65:0]       mag_ext;
    logic [3:0]        dig_load [DIG_N];

    always_comb
    begin
        conv_n = (conversion == CONV_ALT) ? CONV_UDEC : conversion;
        unique case (length)
            LEN_LL:
            begin
                mask    = '1;
                sbit    = value[63];
                steps_n = STEP_W'(16);
            end
            LEN_SHORT:
            begin
                mask    = 64'h0000_0000_0000_FFFF;
                sbit    = value[15];
                steps_n = STEP_W'(4);
            end
            LEN_CHAR:
            begin
                mask    = 64'h0000_0000_0000_00FF;
                sbit    = value[7];
                steps_n = STEP_W'(2);
            end
            default:
            begin
                mask    = 64'h0000_0000_FFFF_FFFF;
                sbit    = value[31];
                steps_n = STEP_W'(8);
            end
        endcase
        cut = value & mask;
        neg = (conv_n == CONV_SDEC) && sbit;
        if (conv_n == CONV_PTR)
            mag = {32'd0, value[31:0]};
        else if (neg)
            mag = (~cut + 64'd1) & mask;
        else
            mag = cut;

        // sign character
        sign_on = 1'b0;
        sign_ch = CH_PLUS;
        if (conv_n == CONV_SDEC)
        begin
            if (neg)
            begin
                sign_on = 1'b1;
                sign_ch = CH_MINUS;
            end
            else if (sign_mode[1])
                sign_on = 1'b1;
            else if (sign_mode == SMODE_SPACE)
            begin
                sign_on = 1'b1;
                sign_ch = CH_SPACE;
            end
        end

        // left-align the magnitude for the BCD shifter
        unique case (length)
            LEN_LL:    aligned = mag;
            LEN_SHORT: aligned = mag << 48;
            LEN_CHAR:  aligned = mag << 56;
            default:   aligned = mag << 32;
        endcase

        // direct digit slicing for octal and hex
        mag_ext = {2'b00, mag};
        for (int i = 0; i < DIG_N; i++)
        begin
            dig_load[i] = 4'd0;
            if (conv_n == CONV_OCT && i < 22)
                dig_load[i] = {1'b0, mag_ext[3*i +: 3]};
            else if ((conv_n == CONV_HEXL || conv_n == CONV_HEXU || conv_n == CONV_PTR)
                     && i < 16)
                dig_load[i] = mag[4*i +: 4];
        end
    end

    // Shift-add-3 binary to BCD, four bits per step
    logic [4*BCD_N-1:0] bcd;
    logic [63:0]        bin;

    always_comb
    begin
        for (int j = 0; j < BCD_N; j++)
            bcd[4*j +: 4] = dig_reg[j];
        bin = bin_reg;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < BCD_N; j++)
            begin
                if (bcd[4*j +: 4] >= 4'd5)
                    bcd[4*j +: 4] = bcd[4*j +: 4] + 4'd3;
            end
            bcd = {bcd[4*BCD_N-2:0], bin[63]};
            bin = {bin[62:0], 1'b0};
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            conv_reg     <= conv_n;
            ladj_reg     <= left_adjust;
            zpad_reg     <= zero_pad;
            alt_reg      <= alternate;
            hasp_reg     <= has_precision;
            wid_reg      <= (width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width;
            prec_reg     <= (precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : precision;
            has_sign_reg <= sign_on;
            sign_reg     <= sign_ch;
            hexpre_reg   <= (conv_n == CONV_HEXL || conv_n == CONV_HEXU)
                            && alternate && (mag != 64'd0);
            upper_reg    <= (conv_n == CONV_HEXU);
            mag_nz_reg   <= (mag != 64'd0);
            chr_reg      <= value[7:0];
            bin_reg      <= aligned;
        end
        else if (cmd.conv_step)
            bin_reg <= bin;
    end

    // Build the digit store
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int i = 0; i < DIG_N; i++)
                dig_reg[i] <= dig_load[i];
        end
        else if (cmd.conv_step)
        begin
            for (int j = 0; j < BCD_N; j++)
                dig_reg[j] <= bcd[4*j +: 4];
        end
    end

    // Count conversion steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= '0;
        else if (cmd.accept)
            steps_reg <= (conv_n == CONV_SDEC || conv_n == CONV_UDEC) ? steps_n : '0;
        else if (cmd.conv_step)
            steps_reg <= steps_reg - STEP_W'(1);
    end

    // Size the digit string
    logic [DIG_W-1:0] hi, sz;

    always_comb
    begin
        hi = '0;
        for (int i = 0; i < DIG_N; i++)
        begin
            if (dig_reg[i] != 4'd0)
                hi = DIG_W'(i + 1);
        end
        if (!mag_nz_reg && hasp_reg && prec_reg == 6'd0)
            sz = '0;
        else if (hi == '0)
            sz = DIG_W'(1);
        else
            sz = hi;
        // octal alternate form: leading zero unless one is already there
        if (conv_reg == CONV_OCT && alt_reg && (sz == '0 || mag_nz_reg))
            sz = sz + DIG_W'(1);
        if (conv_reg == CONV_CHAR)
            sz = DIG_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.size_calc)
            size_reg <= sz;
    end

    // Plan the padding runs
    logic             use_prec, zp;
    logic [CNT_W-1:0] dprec, size_c, body, pad;

    always_comb
    begin
        use_prec = hasp_reg && (conv_reg != CONV_CHAR);
        dprec    = use_prec ? CNT_W'(prec_reg) : '0;
        zp       = zpad_reg && !use_prec;
        size_c   = CNT_W'(size_reg);
        body     = ((dprec > size_c) ? dprec : size_c)
                   + CNT_W'(has_sign_reg) + (hexpre_reg ? CNT_W'(2) : '0);
        pad      = (CNT_W'(wid_reg) > body) ? (CNT_W'(wid_reg) - body) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            lpad_reg <= (!ladj_reg && !zp) ? pad : '0;
            zrun_reg <= (!ladj_reg && zp) ? pad : '0;
            rpad_reg <= ladj_reg ? pad : '0;
            pz_reg   <= (dprec > size_c) ? (dprec - size_c) : '0;
        end
    end

    // Segment lengths
    logic [CNT_W-1:0] seg_len;

    always_comb
    begin
        unique case (cmd.load_seg)
            SEG_LPAD:  seg_len = lpad_reg;
            SEG_SIGN:  seg_len = CNT_W'(1);
            SEG_PRE0:  seg_len = CNT_W'(1);
            SEG_PREX:  seg_len = CNT_W'(1);
            SEG_ZPAD:  seg_len = zrun_reg;
            SEG_PZERO: seg_len = pz_reg;
            SEG_DIGIT: seg_len = CNT_W'(size_reg);
            SEG_RPAD:  seg_len = rpad_reg;
            default:   seg_len = '0;
        endcase
    end

    // Track run and field counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                cnt_reg <= seg_len;
            else if (cmd.emit)
                cnt_reg <= cnt_reg - CNT_W'(1);
            if (cmd.plan)
                left_reg <= body + pad;
            else if (cmd.emit)
                left_reg <= left_reg - CNT_W'(1);
        end
    end

    // Pick the character of the current segment
    logic [DIG_W-1:0] dig_idx;
    logic [7:0]       ch;

    always_comb
    begin
        dig_idx = cnt_reg[DIG_W-1:0] - DIG_W'(1);
        unique case (cmd.seg)
            SEG_LPAD:  ch = CH_SPACE;
            SEG_SIGN:  ch = sign_reg;
            SEG_PRE0:  ch = CH_ZERO;
            SEG_PREX:  ch = upper_reg ? CH_X_UC : CH_X_LC;
            SEG_ZPAD:  ch = CH_ZERO;
            SEG_PZERO: ch = CH_ZERO;
            SEG_DIGIT:
            begin
                if (conv_reg == CONV_CHAR)
                    ch = chr_reg;
                else
                    ch = digit_char(dig_reg[dig_idx], upper_reg);
            end
            SEG_RPAD:  ch = CH_SPACE;
            default:   ch = CH_SPACE;
        endcase
    end

    // Register the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= ch;
            last_reg <= (left_reg == CNT_W'(1));
        end
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // Status to the sequencer
    always_comb
    begin
        sts.conv_done = (steps_reg == '0);
        sts.cnt_last  = (cnt_reg == CNT_W'(1));
        sts.out_last  = (left_reg == CNT_W'(1));
        sts.empty     = (left_reg == '0);
        sts.seg_mask[SEG_LPAD]  = (lpad_reg != '0);
        sts.seg_mask[SEG_SIGN]  = has_sign_reg;
        sts.seg_mask[SEG_PRE0]  = hexpre_reg;
        sts.seg_mask[SEG_PREX]  = hexpre_reg;
        sts.seg_mask[SEG_ZPAD]  = (zrun_reg != '0);
        sts.seg_mask[SEG_PZERO] = (pz_reg != '0);
        sts.seg_mask[SEG_DIGIT] = (size_reg != '0);
        sts.seg_mask[SEG_RPAD]  = (rpad_reg != '0);
    end

endmodule

[hw/rtl/integer_field_formatter_top.sv]
// ----------------------------------------------------------------------------
// integer_field_formatter_top: printf-style integer conversion engine
// Turns one parsed integer or character conversion request into its field
// characters, one word per cycle, with last on the final character.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then
// stays busy through the S decimal conversion steps, sizing, planning and
// the N characters of the field (0 to 50 with the default width and
// precision limits). The binary to BCD shifter handles four bits a cycle,
// so S is 2, 4, 8 or 16 for a char, short, 32-bit or 64-bit decimal value
// and 0 for octal, hex, pointer and char conversions. Characters leave on
// consecutive cycles, each on character/last for exactly one cycle with
// strobe high; the receiver cannot stall them. The final character appears
// in the first cycle busy is low again, so a new request may be taken
// alongside it. An empty field produces no word at all.
// ----------------------------------------------------------------------------
module integer_field_formatter_top #(
    parameter int MAX_WIDTH     = ifmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PRECISION = ifmt_pkg::MAX_PRECISION_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  conversion,
    input  logic [2:0]  length,
    input  logic [63:0] value,
    input  logic        left_adjust,
    input  logic        zero_pad,
    input  logic        alternate,
    input  logic [1:0]  sign_mode,
    input  logic [5:0]  width,
    input  logic        has_precision,
    input  logic [5:0]  precision,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last
);
    import ifmt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ifmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    ifmt_dpath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .conversion    (conversion),
        .length        (length),
        .value         (value),
        .left_adjust   (left_adjust),
        .zero_pad      (zero_pad),
        .alternate     (alternate),
        .sign_mode     (sign_mode),
        .width         (width),
        .has_precision (has_precision),
        .precision     (precision),
        .strobe        (strobe),
        .character     (character),
        .last          (last)
    );

endmodule

[hw/rtl/ifmt_chk.sv]
// ----------------------------------------------------------------------------
// ifmt_chk: port-level checks for the integer field formatter
// Watches the request handshake and the character stream over time.
// ----------------------------------------------------------------------------
module ifmt_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic last
);

    // A taken request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    // Characters of one field come on consecutive cycles
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a field");

    // The final word shows up as the block goes idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("last word while still busy");

    // Any word other than the final one is sent while busy
    a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("word outside a busy period");

endmodule

bind integer_field_formatter_top ifmt_chk u_ifmt_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .last   (last)
);
